>>> rtl/rod_anisotropic_drag_force_defines.svh
// Assertion macros shared by the rod drag RTL.
`ifndef ROD_ANISOTROPIC_DRAG_FORCE_DEFINES_SVH
`define ROD_ANISOTROPIC_DRAG_FORCE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RAD_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rod drag check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define RAD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rod drag check failed");

`endif

>>> rtl/rad_pkg.sv
// Types, constants and fixed-point helpers for the rod drag block.
`default_nettype none
package rad_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_AW + 1;

   localparam logic FUNC_JACOBIAN = 1'b1;

   localparam logic [1:0] REG_DRAG_PARALLEL      = 2'd0;
   localparam logic [1:0] REG_DRAG_PERPENDICULAR = 2'd1;
   localparam logic [1:0] REG_INVERSE_TIME_STEP  = 2'd2;

   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_MID   = 2'd1;
   localparam logic [1:0] ROW_LAST  = 2'd2;

   localparam logic [30:0] DRAG_RESET = 31'd65536;

   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clip;
   } prod_type;

   // One classified item waiting for the back end.
   typedef struct packed {
      logic               is_jac;
      logic [11:0]        dof_base;
      logic [2:0][31:0]   vel;
      logic [2:0][31:0]   tan;
      logic signed [31:0] dot;    // saturated t.u (force)
      logic signed [31:0] scale;  // len (force) or len*inv_dt (Jacobian)
      logic               clip;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   function automatic prod_type q_sat(input logic signed [65:0] x);
      prod_type r;
      r.clip = (x > SAT_MAX) || (x < SAT_MIN);
      if (x > SAT_MAX) begin
         r.value = 32'sh7FFF_FFFF;
      end else if (x < SAT_MIN) begin
         r.value = 32'sh8000_0000;
      end else begin
         r.value = x[31:0];
      end
      return r;
   endfunction

   // Q16.16 product, floor, saturate.
   function automatic prod_type q_mul(input logic signed [32:0] a,
                                      input logic signed [32:0] b);
      logic signed [65:0] p;
      p = a * b;
      return q_sat(p >>> 16);
   endfunction

   function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

   function automatic logic signed [32:0] zx33(input logic [30:0] v);
      return {2'b00, v};
   endfunction

endpackage
`default_nettype wire

>>> rtl/rad_front.sv
// Front end: accepts items, drops out-of-range nodes, forms t.u and len*inv_dt.
`default_nettype none
module rad_front #(
   parameter int MAX_NODES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [9:0]                    req_node_index,
   input  logic signed [31:0]            req_vel_x,
   input  logic signed [31:0]            req_vel_y,
   input  logic signed [31:0]            req_vel_z,
   input  logic signed [31:0]            req_tan_x,
   input  logic signed [31:0]            req_tan_y,
   input  logic signed [31:0]            req_tan_z,
   input  logic [30:0]                   req_seg_length,
   input  logic [30:0]                   inverse_time_step,
   input  logic [rad_pkg::QUEUE_CW-1:0]  q_count,
   output rad_pkg::slot_type             push
);

   logic                        accept;
   logic                        node_ok;
   logic [rad_pkg::QUEUE_CW-1:0] credit;
   logic                        f1_valid_ff, f1_valid_in;
   logic                        f1_jac_ff;
   logic [11:0]                 f1_base_ff;
   logic [2:0][31:0]            f1_vel_ff;
   logic [2:0][31:0]            f1_tan_ff;
   logic [30:0]                 f1_len_ff;
   logic signed [63:0]          f1_prod_ff [3];
   rad_pkg::prod_type           f1_c_ff;
   rad_pkg::prod_type           c_res;
   rad_pkg::prod_type           dot_res;
   logic signed [65:0]          dot_sum;

   // in-flight item counts against the queue so a push always has room
   assign credit    = q_count + rad_pkg::QUEUE_CW'(f1_valid_ff);
   assign req_ready = credit < rad_pkg::QUEUE_CW'(rad_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign node_ok   = int'(req_node_index) < MAX_NODES;

   assign c_res = rad_pkg::q_mul(rad_pkg::zx33(req_seg_length),
                                 rad_pkg::zx33(inverse_time_step));

   always_comb begin
      f1_valid_in = accept && node_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_jac_ff     <= (req_func == rad_pkg::FUNC_JACOBIAN);
         f1_base_ff    <= {req_node_index, 2'b00};
         f1_vel_ff     <= {req_vel_z, req_vel_y, req_vel_x};
         f1_tan_ff     <= {req_tan_z, req_tan_y, req_tan_x};
         f1_len_ff     <= req_seg_length;
         f1_prod_ff[0] <= req_tan_x * req_vel_x;
         f1_prod_ff[1] <= req_tan_y * req_vel_y;
         f1_prod_ff[2] <= req_tan_z * req_vel_z;
         f1_c_ff       <= c_res;
      end
   end

   // exact three-term sum, then floor and saturate
   assign dot_sum = $signed({{2{f1_prod_ff[0][63]}}, f1_prod_ff[0]})
                  + $signed({{2{f1_prod_ff[1][63]}}, f1_prod_ff[1]})
                  + $signed({{2{f1_prod_ff[2][63]}}, f1_prod_ff[2]});
   assign dot_res = rad_pkg::q_sat(dot_sum >>> 16);

   always_comb begin
      push.valid          = f1_valid_ff;
      push.entry.is_jac   = f1_jac_ff;
      push.entry.dof_base = f1_base_ff;
      push.entry.vel      = f1_vel_ff;
      push.entry.tan      = f1_tan_ff;
      push.entry.dot      = dot_res.value;
      push.entry.scale    = f1_jac_ff ? f1_c_ff.value : $signed({1'b0, f1_len_ff});
      push.entry.clip     = f1_jac_ff ? f1_c_ff.clip : dot_res.clip;
   end

endmodule
`default_nettype wire

>>> rtl/rad_queue.sv
// Small FIFO of classified items between front and back ends.
`default_nettype none
module rad_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  rad_pkg::slot_type             push,
   input  logic                          pop,
   output rad_pkg::slot_type             head,
   output logic [rad_pkg::QUEUE_CW-1:0]  count
);

   rad_pkg::entry_type             entries_ff [rad_pkg::QUEUE_DEPTH];
   logic [rad_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [rad_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [rad_pkg::QUEUE_CW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rad_pkg::QUEUE_AW'(push.valid);
      rd_ptr_in = rd_ptr_ff + rad_pkg::QUEUE_AW'(pop);
      count_in  = count_ff + rad_pkg::QUEUE_CW'(push.valid) - rad_pkg::QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule
`default_nettype wire

>>> rtl/rad_back.sv
// Back end: row sequencer and three-stage multiply datapath, one result per cycle while rsp_ready does not stall it.
`default_nettype none
module rad_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [32:0]        drag_diff,
   input  logic [30:0]               drag_perpendicular,
   input  rad_pkg::slot_type         head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [11:0]               rsp_dof_base,
   output logic [1:0]                rsp_row,
   output logic signed [31:0]        rsp_value_0,
   output logic signed [31:0]        rsp_value_1,
   output logic signed [31:0]        rsp_value_2,
   output logic                      rsp_is_jacobian,
   output logic                      rsp_saturated,
   output logic                      rsp_last
);

   logic                enable;
   logic                issue;
   logic [1:0]          row_ff, row_in;
   logic signed [31:0]  t_row;
   rad_pkg::prod_type   x_res [3];
   rad_pkg::prod_type   s_res;
   logic                clip1;

   // stage 1
   logic                s1_valid_ff;
   logic                s1_jac_ff;
   logic [11:0]         s1_base_ff;
   logic [1:0]          s1_row_ff;
   logic                s1_last_ff;
   logic                s1_clip_ff;
   logic signed [31:0]  s1_scale_ff;
   logic signed [31:0]  s1_tan_ff [3];
   logic signed [31:0]  s1_x_ff [3];
   logic signed [31:0]  s1_s_ff;

   // stage 2
   rad_pkg::prod_type   p2_res [3];
   rad_pkg::prod_type   g_res [3];
   logic signed [32:0]  add2 [3];
   logic                clip2;
   logic                s2_valid_ff;
   logic                s2_jac_ff;
   logic [11:0]         s2_base_ff;
   logic [1:0]          s2_row_ff;
   logic                s2_last_ff;
   logic                s2_clip_ff;
   logic signed [31:0]  s2_scale_ff;
   logic signed [31:0]  s2_g_ff [3];

   // result stage
   rad_pkg::prod_type   v_res [3];
   logic                clip3;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [11:0]         rsp_base_ff;
   logic [1:0]          rsp_row_ff;
   logic signed [31:0]  rsp_val_ff [3];
   logic                rsp_jac_ff;
   logic                rsp_clip_ff;
   logic                rsp_last_ff;

   // whole back pipeline moves together; frozen only while a result waits
   assign enable = !rsp_valid_ff || rsp_ready;
   assign issue  = head.valid && enable;
   assign pop    = issue && (!head.entry.is_jac || row_ff == rad_pkg::ROW_LAST);

   always_comb begin
      row_in = row_ff;
      if (issue && head.entry.is_jac) begin
         row_in = (row_ff == rad_pkg::ROW_LAST) ? rad_pkg::ROW_FIRST : row_ff + 2'd1;
      end
   end

   always_comb begin
      unique case (row_ff)
         rad_pkg::ROW_FIRST: t_row = $signed(head.entry.tan[0]);
         rad_pkg::ROW_MID:   t_row = $signed(head.entry.tan[1]);
         default:            t_row = $signed(head.entry.tan[2]);
      endcase
   end

   // stage 1: Jacobian t_r*t_k, force eta_per*u_k and s = d*dot
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         x_res[k] = head.entry.is_jac
            ? rad_pkg::q_mul(rad_pkg::sx33(t_row), rad_pkg::sx33(head.entry.tan[k]))
            : rad_pkg::q_mul(rad_pkg::zx33(drag_perpendicular),
                             rad_pkg::sx33(head.entry.vel[k]));
      end
      s_res = rad_pkg::q_mul(drag_diff, rad_pkg::sx33(head.entry.dot));
      clip1 = head.entry.clip || x_res[0].clip || x_res[1].clip || x_res[2].clip
           || (!head.entry.is_jac && s_res.clip);
   end

   // stage 2: d*m (+eta_per on the diagonal) or s*t_k + eta_per*u_k
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p2_res[k] = s1_jac_ff
            ? rad_pkg::q_mul(drag_diff, rad_pkg::sx33(s1_x_ff[k]))
            : rad_pkg::q_mul(rad_pkg::sx33(s1_s_ff), rad_pkg::sx33(s1_tan_ff[k]));
         if (s1_jac_ff) begin
            add2[k] = (2'(k) == s1_row_ff) ? rad_pkg::zx33(drag_perpendicular) : '0;
         end else begin
            add2[k] = rad_pkg::sx33(s1_x_ff[k]);
         end
         g_res[k] = rad_pkg::q_sat($signed({{34{p2_res[k].value[31]}}, p2_res[k].value})
                                 + $signed({{33{add2[k][32]}}, add2[k]}));
      end
      clip2 = s1_clip_ff || p2_res[0].clip || p2_res[1].clip || p2_res[2].clip
           || g_res[0].clip || g_res[1].clip || g_res[2].clip;
   end

   // stage 3: scale by len or len*inv_dt
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         v_res[k] = rad_pkg::q_mul(rad_pkg::sx33(s2_g_ff[k]), rad_pkg::sx33(s2_scale_ff));
      end
      clip3 = s2_clip_ff || v_res[0].clip || v_res[1].clip || v_res[2].clip;
   end

   assign rsp_valid_in = enable ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= rad_pkg::ROW_FIRST;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (enable) begin
            s1_valid_ff <= issue;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_jac_ff   <= head.entry.is_jac;
         s1_base_ff  <= head.entry.dof_base;
         s1_row_ff   <= head.entry.is_jac ? row_ff : rad_pkg::ROW_FIRST;
         s1_last_ff  <= !head.entry.is_jac || (row_ff == rad_pkg::ROW_LAST);
         s1_clip_ff  <= clip1;
         s1_scale_ff <= head.entry.scale;
         s1_s_ff     <= s_res.value;
         for (int k = 0; k < 3; k++) begin
            s1_tan_ff[k] <= $signed(head.entry.tan[k]);
            s1_x_ff[k]   <= x_res[k].value;
         end

         s2_jac_ff   <= s1_jac_ff;
         s2_base_ff  <= s1_base_ff;
         s2_row_ff   <= s1_row_ff;
         s2_last_ff  <= s1_last_ff;
         s2_clip_ff  <= clip2;
         s2_scale_ff <= s1_scale_ff;
         for (int k = 0; k < 3; k++) begin
            s2_g_ff[k] <= g_res[k].value;
         end

         rsp_jac_ff  <= s2_jac_ff;
         rsp_base_ff <= s2_base_ff;
         rsp_row_ff  <= s2_row_ff;
         rsp_last_ff <= s2_last_ff;
         rsp_clip_ff <= clip3;
         for (int k = 0; k < 3; k++) begin
            rsp_val_ff[k] <= v_res[k].value;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dof_base    = rsp_base_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_value_0     = rsp_val_ff[0];
   assign rsp_value_1     = rsp_val_ff[1];
   assign rsp_value_2     = rsp_val_ff[2];
   assign rsp_is_jacobian = rsp_jac_ff;
   assign rsp_saturated   = rsp_clip_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

>>> rtl/rod_anisotropic_drag_force.sv
// Top level of the rod anisotropic drag block: CSRs, front end, queue, back end.
//
//   Channel  Dir  Handshake          Carries
//   req_     in   req_valid/ready    func, node, velocity, tangent, length
//   rsp_     out  rsp_valid/ready    dof base, row, three values, flags
//   csr_     in   csr_wr_en          register index and 31-bit data
//
// Path: accept -> front product stage -> queue -> three back stages.
// Rate: a force item gives one row and a Jacobian item three rows, one row per cycle
//   through the single back-end datapath while rsp_ready does not stall it.
// Reset (synchronous): empties the queue and pipeline, registers back to 1.0.
// Stalls: rsp_ready low while a result waits freezes the back end; the 4-entry queue keeps the front
//   going, and req_ready drops once queued plus in-flight items reach 4.
`default_nettype none
`include "rod_anisotropic_drag_force_defines.svh"
module rod_anisotropic_drag_force #(
   parameter int MAX_NODES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   // input items
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [9:0]          req_node_index,
   input  logic signed [31:0]  req_vel_x,
   input  logic signed [31:0]  req_vel_y,
   input  logic signed [31:0]  req_vel_z,
   input  logic signed [31:0]  req_tan_x,
   input  logic signed [31:0]  req_tan_y,
   input  logic signed [31:0]  req_tan_z,
   input  logic [30:0]         req_seg_length,
   // result items
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [11:0]         rsp_dof_base,
   output logic [1:0]          rsp_row,
   output logic signed [31:0]  rsp_value_0,
   output logic signed [31:0]  rsp_value_1,
   output logic signed [31:0]  rsp_value_2,
   output logic                rsp_is_jacobian,
   output logic                rsp_saturated,
   output logic                rsp_last,
   // configuration writes
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [30:0]         csr_wdata
);

   logic [30:0]                   drag_par_ff;
   logic [30:0]                   drag_per_ff;
   logic [30:0]                   inv_dt_ff;
   logic signed [32:0]            drag_diff;
   rad_pkg::slot_type             q_push;
   rad_pkg::slot_type             q_head;
   logic                          q_pop;
   logic [rad_pkg::QUEUE_CW-1:0]  q_count;

   // The user must change registers only while idle (not enforced here), so no shadowing is needed.
   always_ff @(posedge clock) begin
      if (reset) begin
         drag_par_ff <= rad_pkg::DRAG_RESET;
         drag_per_ff <= rad_pkg::DRAG_RESET;
         inv_dt_ff   <= rad_pkg::DRAG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rad_pkg::REG_DRAG_PARALLEL:      drag_par_ff <= csr_wdata;
            rad_pkg::REG_DRAG_PERPENDICULAR: drag_per_ff <= csr_wdata;
            rad_pkg::REG_INVERSE_TIME_STEP:  inv_dt_ff   <= csr_wdata;
            default: ;  // no register there
         endcase
      end
   end

   // eta_par - eta_per, exact in 33 bits
   assign drag_diff = rad_pkg::zx33(drag_par_ff) - rad_pkg::zx33(drag_per_ff);

   rad_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_node_index    (req_node_index),
      .req_vel_x         (req_vel_x),
      .req_vel_y         (req_vel_y),
      .req_vel_z         (req_vel_z),
      .req_tan_x         (req_tan_x),
      .req_tan_y         (req_tan_y),
      .req_tan_z         (req_tan_z),
      .req_seg_length    (req_seg_length),
      .inverse_time_step (inv_dt_ff),
      .q_count           (q_count),
      .push              (q_push)
   );

   rad_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .head  (q_head),
      .count (q_count)
   );

   rad_back u_back (
      .clock              (clock),
      .reset              (reset),
      .drag_diff          (drag_diff),
      .drag_perpendicular (drag_per_ff),
      .head               (q_head),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_dof_base       (rsp_dof_base),
      .rsp_row            (rsp_row),
      .rsp_value_0        (rsp_value_0),
      .rsp_value_1        (rsp_value_1),
      .rsp_value_2        (rsp_value_2),
      .rsp_is_jacobian    (rsp_is_jacobian),
      .rsp_saturated      (rsp_saturated),
      .rsp_last           (rsp_last)
   );

   // Front credit must leave room for every push.
   `RAD_ASSERT_IMPL(a_push_room, q_push.valid, q_count < rad_pkg::QUEUE_CW'(rad_pkg::QUEUE_DEPTH))
   // A pushed item cannot leave the queue on the same edge it lands.
   `RAD_ASSERT_NEXT(a_push_lands, q_push.valid, q_count != '0)
   // A force item gives exactly one result, row 0.
   `RAD_ASSERT_IMPL(a_force_one, rsp_valid && !rsp_is_jacobian, rsp_last && (rsp_row == rad_pkg::ROW_FIRST))
   // Jacobian rows end on the last row and only there.
   `RAD_ASSERT_IMPL(a_jac_last, rsp_valid && rsp_is_jacobian, rsp_last == (rsp_row == rad_pkg::ROW_LAST))

endmodule
`default_nettype wire
